/* rtl/dnle_pkg.sv */
// Package for the DNS name label encoder.
// Holds sizing constants, the controller state type and the command and status
// structs that pass between the controller and the datapath. No dependencies.
`default_nettype none

package dnle_pkg;

  localparam int LABEL_MAX = 62;
  localparam int CNT_W     = $clog2(LABEL_MAX + 1);
  localparam int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'd46;
  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHAR,
    ST_TERM
  } state_t;

  typedef struct packed {
    logic wr_char;
    logic set_trunc;
    logic end_label;
    logic load_len;
    logic load_char;
    logic load_term;
    logic idx_inc;
    logic clr_label;
  } dp_cmd_t;

  typedef struct packed {
    logic in_end;
    logic in_dot;
    logic room;
    logic count_zero;
    logic last_char;
    logic term;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/dnle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read returns the old word on a same-address write.
`default_nettype none

module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/dnle_ctrl.sv */
// Controller for the DNS name label encoder.
// Sequences character intake and label replay; depends on dnle_pkg.
`default_nettype none

module dnle_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dnle_pkg::dp_stat_t stat,
  output dnle_pkg::dp_cmd_t       cmd
);

  dnle_pkg::state_t state_r;
  dnle_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dnle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dnle_pkg::ST_IDLE: begin
        if (in_valid && (stat.in_end || stat.in_dot)) begin
          state_nxt = dnle_pkg::ST_LEN;
        end
      end
      dnle_pkg::ST_LEN: begin
        if (stat.out_free) begin
          if (!stat.count_zero) begin
            state_nxt = dnle_pkg::ST_CHAR;
          end else if (stat.term) begin
            state_nxt = dnle_pkg::ST_TERM;
          end else begin
            state_nxt = dnle_pkg::ST_IDLE;
          end
        end
      end
      dnle_pkg::ST_CHAR: begin
        if (stat.out_free && stat.last_char) begin
          state_nxt = stat.term ? dnle_pkg::ST_TERM : dnle_pkg::ST_IDLE;
        end
      end
      dnle_pkg::ST_TERM: begin
        if (stat.out_free) begin
          state_nxt = dnle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dnle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      dnle_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (stat.in_end || stat.in_dot) begin
            cmd.end_label = 1'b1;
          end else if (stat.room) begin
            cmd.wr_char = 1'b1;
          end else begin
            cmd.set_trunc = 1'b1;
          end
        end
      end
      dnle_pkg::ST_LEN: begin
        if (stat.out_free) begin
          cmd.load_len  = 1'b1;
          cmd.clr_label = stat.count_zero;
        end
      end
      dnle_pkg::ST_CHAR: begin
        if (stat.out_free) begin
          cmd.load_char = 1'b1;
          cmd.idx_inc   = !stat.last_char;
          cmd.clr_label = stat.last_char;
        end
      end
      dnle_pkg::ST_TERM: begin
        if (stat.out_free) begin
          cmd.load_term = 1'b1;
        end
      end
      default: begin
        in_stall = 1'b1;
        cmd      = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dnle_dp.sv */
// Datapath for the DNS name label encoder.
// Label store, count, flags, replay index and output register; uses dnle_pkg
// and dnle_ram.
`default_nettype none

module dnle_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_cmd,
  input  wire logic [dnle_pkg::BYTE_W-1:0]          in_char_in,
  input  wire dnle_pkg::dp_cmd_t                    cmd,
  output dnle_pkg::dp_stat_t                        stat,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [dnle_pkg::BYTE_W-1:0]          out_byte_out,
  output logic                                      out_last,
  output logic                                      out_overflow
);

  logic [dnle_pkg::CNT_W-1:0]  count_r;
  logic [dnle_pkg::CNT_W-1:0]  count_nxt;
  logic                        trunc_r;
  logic                        trunc_nxt;
  logic                        term_r;
  logic                        term_nxt;
  logic [dnle_pkg::ADDR_W-1:0] idx_r;
  logic [dnle_pkg::ADDR_W-1:0] idx_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [dnle_pkg::BYTE_W-1:0] byte_r;
  logic [dnle_pkg::BYTE_W-1:0] byte_nxt;
  logic                        last_r;
  logic                        last_nxt;
  logic                        ovf_r;
  logic                        ovf_nxt;
  logic [dnle_pkg::BYTE_W-1:0] rdata;

  dnle_ram #(
    .WIDTH (dnle_pkg::BYTE_W),
    .DEPTH (dnle_pkg::LABEL_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_char),
    .waddr (count_r[dnle_pkg::ADDR_W-1:0]),
    .wdata (in_char_in),
    .raddr (idx_nxt),
    .rdata (rdata)
  );

  always_comb begin
    stat.in_end     = (in_cmd == dnle_pkg::CMD_END);
    stat.in_dot     = (in_char_in == dnle_pkg::DOT_CHAR);
    stat.room       = (count_r < dnle_pkg::CNT_W'(dnle_pkg::LABEL_MAX));
    stat.count_zero = (count_r == '0);
    stat.last_char  = ((dnle_pkg::CNT_W'(idx_r) + dnle_pkg::CNT_W'(1)) == count_r);
    stat.term       = term_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    count_nxt = count_r;
    trunc_nxt = trunc_r;
    term_nxt  = term_r;
    idx_nxt   = idx_r;
    if (cmd.wr_char) begin
      count_nxt = count_r + dnle_pkg::CNT_W'(1);
    end
    if (cmd.set_trunc) begin
      trunc_nxt = 1'b1;
    end
    if (cmd.end_label) begin
      term_nxt = stat.in_end;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + dnle_pkg::ADDR_W'(1);
    end
    if (cmd.clr_label) begin
      count_nxt = '0;
      trunc_nxt = 1'b0;
      idx_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    if (cmd.load_len) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = dnle_pkg::BYTE_W'(count_r);
      last_nxt      = 1'b0;
      ovf_nxt       = trunc_r;
    end else if (cmd.load_char) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = rdata;
      last_nxt      = 1'b0;
      ovf_nxt       = trunc_r;
    end else if (cmd.load_term) begin
      out_valid_nxt = 1'b1;
      byte_nxt      = dnle_pkg::TERM_BYTE;
      last_nxt      = 1'b1;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      trunc_r     <= 1'b0;
      term_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      trunc_r     <= trunc_nxt;
      term_r      <= term_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte_out = byte_r;
  assign out_last     = last_r;
  assign out_overflow = ovf_r;

endmodule

`default_nettype wire

/* rtl/dns_name_label_encoder.sv */
// Top level of the DNS name label encoder.
// Joins dnle_ctrl and dnle_dp; depends on dnle_pkg.
//
//   channel  | handshake            | beat fields
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_stall  | in_cmd, in_char_in
//   out      | out_valid / out_stall| out_byte_out, out_last, out_overflow
//
// A name character beat is taken in the idle state. A dot holding n characters
// is taken in the idle state, then the length byte is loaded, then one byte per
// character read from the label store. End of name adds the terminator byte
// after them. Reset is synchronous and active low; it clears the label count
// and flags but not the store. A stalled output holds its beat; the input side
// stays open for characters only while no label is being replayed.
`default_nettype none

module dns_name_label_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_cmd,
  input  wire logic [dnle_pkg::BYTE_W-1:0] in_char_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [dnle_pkg::BYTE_W-1:0] out_byte_out,
  output logic                             out_last,
  output logic                             out_overflow
);

  dnle_pkg::dp_cmd_t  cmd;
  dnle_pkg::dp_stat_t stat;

  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnle_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_cmd),
    .in_char_in   (in_char_in),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_out (out_byte_out),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule

`default_nettype wire
